@@ rtl/skf_pkg.sv @@
// skf_pkg: shared widths, reset values, register indexes and the
// controller-to-datapath command/status structs of the scalar kalman filter.
// No dependencies.
`default_nettype none

package skf_pkg;

   // fixed-point formats
   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int GAIN_W  = FRAC_W + 1;
   localparam int DEN_W   = DATA_W + 1;
   localparam int REM_W   = DATA_W + 2;
   localparam int MAG_W   = DATA_W + 1;
   localparam int PROD_W  = MAG_W + GAIN_W;
   localparam int SUM_W   = DATA_W + 3;

   // restoring division: one integer step plus one step per fraction bit
   localparam int DIV_STEPS = FRAC_W + 1;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // register reset values
   localparam logic [DATA_W-1:0] Q_RESET  = DATA_W'(918);
   localparam logic [DATA_W-1:0] R_RESET  = DATA_W'(36045);
   localparam logic [DATA_W-1:0] P0_RESET = DATA_W'(5308);

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COVARIANCE = 2'd2;

   // input item kinds
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic restart;     // reload estimate and covariance
      logic start;       // capture sample, form predicted covariance
      logic den;         // form denominator and difference
      logic div_step;    // one restoring division step
      logic div_first;   // first step has no shift
      logic mul_est;     // multiply |difference| by gain
      logic upd_est;     // apply correction with clamping
      logic mul_cov;     // multiply covariance by (1 - gain)
      logic upd_cov;     // write new covariance
      logic set_err;     // flag zero denominator
      logic out_load;    // load result register
   } skf_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic den_zero;
   } skf_stat_type;

endpackage

`default_nettype wire

@@ rtl/scalar_kalman_filter_core.sv @@
// scalar_kalman_filter_core: top level of the one-dimensional fixed-point
// kalman filter. Depends on skf_pkg, skf_ctrl and skf_datapath.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   req_kind, req_measurement
//   rsp      out        rsp_valid/stall   rsp_estimate, rsp_gain, rsp_error
//   csr      in         csr_write         csr_index, csr_wdata
//
// after its transfer a sample passes the denominator state, 17 divider steps,
// the estimate and covariance multiply and update states and one result load;
// the next transfer can follow in the cycle after that result load.
// a zero denominator skips the divider steps and the estimate update.
// a restart item gives no result; reset restores the defaults.
// a stalled result waits in its register; the next item runs up to its result load.
`default_nettype none

module scalar_kalman_filter_core
   import skf_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire                       req_kind,
   input  wire  signed [DATA_W-1:0]  req_measurement,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_estimate,
   output logic [GAIN_W-1:0]         rsp_gain,
   output logic                      rsp_error,
   input  wire                       csr_write,
   input  wire  [CSR_IDX_W-1:0]      csr_index,
   input  wire  [DATA_W-1:0]         csr_wdata
);

   skf_cmd_type  cmd;
   skf_stat_type stat;

   // sequencer
   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic and state
   skf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_measurement (req_measurement),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_estimate    (rsp_estimate),
      .rsp_gain        (rsp_gain),
      .rsp_error       (rsp_error)
   );

endmodule

`default_nettype wire

@@ rtl/skf_datapath.sv @@
// skf_datapath: configuration registers, filter state, restoring divider,
// shared multiplier and result register of the scalar kalman filter.
// Depends on skf_pkg.
`default_nettype none

module skf_datapath
   import skf_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_write,
   input  wire  [CSR_IDX_W-1:0]      csr_index,
   input  wire  [DATA_W-1:0]         csr_wdata,
   input  wire  signed [DATA_W-1:0]  req_measurement,
   input  wire  skf_cmd_type         cmd,
   output skf_stat_type              stat,
   output logic signed [DATA_W-1:0]  rsp_estimate,
   output logic [GAIN_W-1:0]         rsp_gain,
   output logic                      rsp_error
);

   logic [DATA_W-1:0]        q_ff, r_ff, p0_ff;
   logic signed [DATA_W-1:0] est_ff, est_in;
   logic [DATA_W-1:0]        cov_ff, cov_in;
   logic signed [DATA_W-1:0] meas_ff;
   logic [DATA_W-1:0]        p_ff;
   logic [DEN_W-1:0]         den_ff;
   logic signed [MAG_W:0]    diff_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [GAIN_W-1:0]        quo_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     err_ff;
   logic signed [DATA_W-1:0] out_est_ff;
   logic [GAIN_W-1:0]        out_gain_ff;
   logic                     out_err_ff;

   logic [DATA_W:0]          p_sum;
   logic [DATA_W-1:0]        p_sat;
   logic [REM_W-1:0]         rem_sh;
   logic                     div_ge;
   logic [MAG_W-1:0]         mul_a;
   logic [GAIN_W-1:0]        mul_b;
   logic signed [SUM_W-1:0]  est_ext, step_ext, est_sum;
   logic                     est_ovf;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff  <= Q_RESET;
         r_ff  <= R_RESET;
         p0_ff <= P0_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:      q_ff  <= csr_wdata;
            CSR_MEASUREMENT_NOISE:  r_ff  <= csr_wdata;
            CSR_INITIAL_COVARIANCE: p0_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // predicted covariance with saturation
   assign p_sum = {1'b0, cov_ff} + {1'b0, q_ff};
   assign p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

   // restoring division step
   assign rem_sh = cmd.div_first ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign div_ge = rem_sh >= REM_W'(den_ff);
   assign rem_in = div_ge ? rem_sh - REM_W'(den_ff) : rem_sh;

   // shared multiplier operand select
   assign mul_a = cmd.mul_cov ? MAG_W'(p_ff) : mag_ff;
   assign mul_b = cmd.mul_cov ? GAIN_ONE - quo_ff : quo_ff;

   // estimate correction with clamping to the signed range
   assign est_ext  = SUM_W'(est_ff);
   assign step_ext = $signed({1'b0, prod_ff[PROD_W-1:FRAC_W]});
   assign est_sum  = neg_ff ? est_ext - step_ext : est_ext + step_ext;
   assign est_ovf  = (est_sum[SUM_W-1:DATA_W-1] != '0)
                     && (est_sum[SUM_W-1:DATA_W-1] != '1);

   always_comb begin
      est_in = est_ff;
      if (est_ovf) begin
         est_in = est_sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         est_in = est_sum[DATA_W-1:0];
      end
   end

   assign cov_in = prod_ff[DATA_W+FRAC_W-1:FRAC_W];

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
         cov_ff <= P0_RESET;
      end else if (cmd.restart) begin
         est_ff <= '0;
         cov_ff <= p0_ff;
      end else begin
         if (cmd.upd_est) begin
            est_ff <= est_in;
         end
         if (cmd.upd_cov) begin
            cov_ff <= cov_in;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         meas_ff <= req_measurement;
         p_ff    <= p_sat;
         err_ff  <= 1'b0;
      end
      if (cmd.den) begin
         den_ff  <= {1'b0, p_ff} + {1'b0, r_ff};
         diff_ff <= (MAG_W+1)'(meas_ff) - (MAG_W+1)'(est_ff);
         rem_ff  <= REM_W'(p_ff);
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[GAIN_W-2:0], div_ge};
         mag_ff <= diff_ff[MAG_W] ? MAG_W'(-diff_ff) : MAG_W'(diff_ff);
         neg_ff <= diff_ff[MAG_W];
      end
      if (cmd.mul_est || cmd.mul_cov) begin
         prod_ff <= {{GAIN_W{1'b0}}, mul_a} * {{MAG_W{1'b0}}, mul_b};
      end
      if (cmd.set_err || (cmd.upd_est && est_ovf)) begin
         err_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         out_est_ff  <= est_ff;
         out_gain_ff <= quo_ff;
         out_err_ff  <= err_ff;
      end
   end

   assign stat.den_zero = (den_ff == '0);
   assign rsp_estimate  = out_est_ff;
   assign rsp_gain      = out_gain_ff;
   assign rsp_error     = out_err_ff;

endmodule

`default_nettype wire

@@ rtl/skf_ctrl.sv @@
// skf_ctrl: sequencer of the scalar kalman filter; drives datapath commands
// and both handshakes. Depends on skf_pkg.
`default_nettype none

module skf_ctrl
   import skf_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   input  wire           req_kind,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   input  wire skf_stat_type stat,
   output skf_cmd_type   cmd
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DEN  = 8'b0000_0010,
      ST_DIV  = 8'b0000_0100,
      ST_MEST = 8'b0000_1000,
      ST_UEST = 8'b0001_0000,
      ST_MCOV = 8'b0010_0000,
      ST_UCOV = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } skf_state_type;

   skf_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_xfer, out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_kind == KIND_RESTART) begin
                  cmd.restart = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_DEN;
               end
            end
         end
         ST_DEN: begin
            cmd.den  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.den_zero) begin
               cmd.set_err = 1'b1;
               state_in    = ST_MCOV;
            end else begin
               cmd.div_step  = 1'b1;
               cmd.div_first = (cnt_ff == '0);
               cnt_in        = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_in = ST_MEST;
               end
            end
         end
         ST_MEST: begin
            cmd.mul_est = 1'b1;
            state_in    = ST_UEST;
         end
         ST_UEST: begin
            cmd.upd_est = 1'b1;
            state_in    = ST_MCOV;
         end
         ST_MCOV: begin
            cmd.mul_cov = 1'b1;
            state_in    = ST_UCOV;
         end
         ST_UCOV: begin
            cmd.upd_cov = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
